@@ rtl/gwfr_pkg.sv @@
// Shared types and constants for the grid water flow relaxation block.
`timescale 1ns / 1ps
package gwfr_pkg;

    localparam int LEVEL_W    = 34;   // water + ground, signed
    localparam int SUM_W      = 37;   // sum of eight levels, signed
    localparam int DIV_W      = 37;   // divider dividend width
    localparam int CNT_W      = 4;    // lower neighbour count, 0..8
    localparam int NB_COUNT   = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [6:0]  GRID_SIZE_RESET = 7'd64;
    localparam logic [15:0] DRY_RESET       = 16'd66;

    localparam logic CFG_GRID_SIZE = 1'b0;
    localparam logic CFG_DRY       = 1'b1;

    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_RUN   = 2'd2;

    typedef struct packed {
        logic [1:0]         action;
        logic [11:0]        cell_index;
        logic signed [31:0] ground_in;
        logic [31:0]        water_in;
        logic [9:0]         pass_count;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         reply_kind;
        logic [31:0]        water_out;
        logic signed [31:0] ground_out;
        logic               bad_index;
    } out_item_t;

    typedef enum logic [1:0] {
        ADDR_ITEM,
        ADDR_CENTER,
        ADDR_NB
    } addr_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_C_RD,
        ST_C_EVAL,
        ST_N_RD,
        ST_N_EVAL,
        ST_CHK,
        ST_DIV_AVG,
        ST_WR_C,
        ST_DIV_SHARE,
        ST_UPD,
        ST_ADV,
        ST_POST
    } state_t;

    typedef struct packed {
        logic      load_item;
        addr_sel_t addr_sel;
        logic      rd;
        logic      wr_item;
        logic      wr_center;
        logic      wr_nb;
        logic      cap_center;
        logic      cap_nb;
        logic      k_clr;
        logic      k_inc;
        logic      div_start;
        logic      div_share;
        logic      cap_avg;
        logic      cap_share;
        logic      scan_init;
        logic      scan_adv;
        logic      pass_init;
        logic      pass_dec;
        logic      out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [1:0] action;
        logic       bad;
        logic       run_empty;
        logic       w_zero;
        logic       cnt_zero;
        logic       k_last;
        logic       scan_last;
        logic       pass_last;
        logic       div_done;
        logic       out_busy;
    } dp_status_t;

endpackage

@@ rtl/gwfr_div.sv @@
// Restoring divider, one quotient bit per cycle, small unsigned divisor.
`timescale 1ns / 1ps
module gwfr_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [gwfr_pkg::DIV_W-1:0] dividend,
    input  logic [gwfr_pkg::CNT_W-1:0] divisor,
    output logic [gwfr_pkg::DIV_W-1:0] quotient,
    output logic [gwfr_pkg::CNT_W-1:0] remainder,
    output logic                      done
);

    localparam int STEP_W = $clog2(gwfr_pkg::DIV_W + 1);

    logic                       busy_reg, busy_next;
    logic [STEP_W-1:0]          step_reg, step_next;
    logic [gwfr_pkg::DIV_W-1:0] quo_reg, quo_next;
    logic [gwfr_pkg::CNT_W-1:0] rem_reg, rem_next;
    logic [gwfr_pkg::CNT_W-1:0] dvs_reg, dvs_next;
    logic [gwfr_pkg::CNT_W:0]   trial;

    assign trial     = {rem_reg, quo_reg[gwfr_pkg::DIV_W-1]};
    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = busy_reg && (step_reg == '0);

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(gwfr_pkg::DIV_W);
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                step_next = step_reg - 1'b1;
                if (trial >= {1'b0, dvs_reg})
                begin
                    rem_next = gwfr_pkg::CNT_W'(trial - {1'b0, dvs_reg});
                    quo_next = {quo_reg[gwfr_pkg::DIV_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[gwfr_pkg::CNT_W-1:0];
                    quo_next = {quo_reg[gwfr_pkg::DIV_W-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

endmodule

@@ rtl/gwfr_dp.sv @@
// Datapath: cell stores, scan counters, neighbour accumulation and result register.
`timescale 1ns / 1ps
module gwfr_dp #(
    parameter int MAX_EDGE = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  gwfr_pkg::in_item_t              in_data,
    input  logic                            out_stall,
    output logic                            out_valid,
    output gwfr_pkg::out_item_t             out_data,
    input  logic                            cfg_valid,
    input  logic                            cfg_index,
    input  logic [gwfr_pkg::CFG_DATA_W-1:0] cfg_data,
    input  gwfr_pkg::ctrl_cmd_t             cmd,
    output gwfr_pkg::dp_status_t            sts
);

    localparam int DEPTH = MAX_EDGE * MAX_EDGE;
    localparam int AW    = $clog2(DEPTH);
    localparam int EW    = $clog2(MAX_EDGE + 1);
    localparam int SQ_W  = 2 * EW;
    localparam int H_W   = gwfr_pkg::SUM_W + 2;

    logic [31:0] ground_mem [DEPTH];
    logic [31:0] water_mem  [DEPTH];

    logic [6:0]  grid_size_reg;
    logic [15:0] dry_reg;

    gwfr_pkg::in_item_t  item_reg;
    gwfr_pkg::out_item_t out_reg;
    logic                out_valid_reg;

    logic [31:0] rd_water_reg, rd_ground_reg;

    logic [EW-1:0] x_reg, y_reg;
    logic [AW-1:0] c_reg;
    logic [9:0]    pass_left_reg;

    logic [31:0]                        cw_reg;
    logic signed [gwfr_pkg::LEVEL_W-1:0] cur_reg;
    logic signed [gwfr_pkg::SUM_W-1:0]   sum_reg;
    logic [gwfr_pkg::CNT_W-1:0]         cnt_reg;
    logic [gwfr_pkg::NB_COUNT-1:0]      mask_reg;
    logic [31:0]                        nbw_reg [gwfr_pkg::NB_COUNT];
    logic [2:0]                         k_reg;
    logic [31:0]                        excess_reg;
    logic [31:0]                        share_reg;

    logic [EW-1:0]   n;
    logic [SQ_W-1:0] nsq;
    logic            bad;
    logic [AW-1:0]   n_a;
    logic [AW-1:0]   nb_addr;
    logic [AW-1:0]   addr;
    logic            water_we, ground_we;
    logic [31:0]     water_wdata;
    logic signed [gwfr_pkg::LEVEL_W-1:0] lv;
    logic [31:0]     remain;
    logic [32:0]     sat_sum;
    logic            sum_neg;
    logic [gwfr_pkg::DIV_W-1:0] sum_mag;
    logic [gwfr_pkg::DIV_W-1:0] div_q;
    logic [gwfr_pkg::CNT_W-1:0] div_r;
    logic [gwfr_pkg::DIV_W-1:0] div_dividend;
    logic            div_done;
    logic signed [H_W-1:0] avg, h;
    logic [31:0]     excess;

    assign n   = (32'(grid_size_reg) > MAX_EDGE) ? EW'(MAX_EDGE) : EW'(grid_size_reg);
    assign nsq = SQ_W'(n) * SQ_W'(n);
    assign bad = 32'(item_reg.cell_index) >= 32'(nsq);
    assign n_a = AW'(n);

    always_comb
    begin
        case (k_reg)
            3'd0:    nb_addr = c_reg - n_a - 1'b1;
            3'd1:    nb_addr = c_reg - n_a;
            3'd2:    nb_addr = c_reg - n_a + 1'b1;
            3'd3:    nb_addr = c_reg - 1'b1;
            3'd4:    nb_addr = c_reg + 1'b1;
            3'd5:    nb_addr = c_reg + n_a - 1'b1;
            3'd6:    nb_addr = c_reg + n_a;
            default: nb_addr = c_reg + n_a + 1'b1;
        endcase
    end

    always_comb
    begin
        case (cmd.addr_sel)
            gwfr_pkg::ADDR_ITEM:   addr = AW'(item_reg.cell_index);
            gwfr_pkg::ADDR_CENTER: addr = c_reg;
            default:               addr = nb_addr;
        endcase
    end

    // Level of the cell just read
    assign lv = $signed({2'b00, rd_water_reg}) + gwfr_pkg::LEVEL_W'($signed(rd_ground_reg));

    assign remain  = cw_reg - excess_reg;
    assign sat_sum = {1'b0, nbw_reg[k_reg]} + {1'b0, share_reg};

    always_comb
    begin
        water_we    = 1'b0;
        ground_we   = 1'b0;
        water_wdata = item_reg.water_in;
        if (cmd.wr_item)
        begin
            water_we  = 1'b1;
            ground_we = 1'b1;
        end
        else if (cmd.wr_center)
        begin
            water_we    = 1'b1;
            water_wdata = (remain < {16'd0, dry_reg}) ? 32'd0 : remain;
        end
        else if (cmd.wr_nb)
        begin
            water_we    = mask_reg[k_reg];
            water_wdata = sat_sum[32] ? 32'hFFFF_FFFF : sat_sum[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (water_we)
        begin
            water_mem[addr] <= water_wdata;
        end
        if (ground_we)
        begin
            ground_mem[addr] <= item_reg.ground_in;
        end
        if (cmd.rd)
        begin
            rd_water_reg  <= water_mem[addr];
            rd_ground_reg <= ground_mem[addr];
        end
    end

    // Floor average from the magnitude quotient
    assign sum_neg      = sum_reg < 0;
    assign sum_mag      = sum_neg ? gwfr_pkg::DIV_W'(-sum_reg) : gwfr_pkg::DIV_W'(sum_reg);
    assign div_dividend = cmd.div_share ? gwfr_pkg::DIV_W'(excess_reg) : sum_mag;

    gwfr_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (cnt_reg),
        .quotient  (div_q),
        .remainder (div_r),
        .done      (div_done)
    );

    always_comb
    begin
        if (sum_neg)
        begin
            avg = -$signed({2'b00, div_q}) - H_W'(div_r != '0);
        end
        else
        begin
            avg = $signed({2'b00, div_q});
        end
        h      = H_W'(cur_reg) - avg;
        excess = (h > $signed(H_W'(cw_reg))) ? cw_reg : h[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_size_reg <= gwfr_pkg::GRID_SIZE_RESET;
            dry_reg       <= gwfr_pkg::DRY_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                gwfr_pkg::CFG_GRID_SIZE: grid_size_reg <= cfg_data[6:0];
                default:                 dry_reg       <= cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= in_data;
        end
        if (cmd.scan_init)
        begin
            x_reg <= EW'(1);
            y_reg <= EW'(1);
            c_reg <= n_a + 1'b1;
        end
        else if (cmd.scan_adv)
        begin
            if (x_reg == n - EW'(2))
            begin
                x_reg <= EW'(1);
                y_reg <= y_reg + 1'b1;
                c_reg <= c_reg + AW'(3);
            end
            else
            begin
                x_reg <= x_reg + 1'b1;
                c_reg <= c_reg + 1'b1;
            end
        end
        if (cmd.pass_init)
        begin
            pass_left_reg <= item_reg.pass_count;
        end
        else if (cmd.pass_dec)
        begin
            pass_left_reg <= pass_left_reg - 1'b1;
        end
        if (cmd.cap_center)
        begin
            cw_reg   <= rd_water_reg;
            cur_reg  <= lv;
            sum_reg  <= '0;
            cnt_reg  <= '0;
            mask_reg <= '0;
        end
        if (cmd.cap_nb)
        begin
            nbw_reg[k_reg] <= rd_water_reg;
            if (lv < cur_reg)
            begin
                sum_reg         <= sum_reg + gwfr_pkg::SUM_W'(lv);
                cnt_reg         <= cnt_reg + 1'b1;
                mask_reg[k_reg] <= 1'b1;
            end
        end
        if (cmd.k_clr || cmd.cap_center)
        begin
            k_reg <= '0;
        end
        else if (cmd.k_inc)
        begin
            k_reg <= k_reg + 1'b1;
        end
        if (cmd.cap_avg)
        begin
            excess_reg <= excess;
        end
        if (cmd.cap_share)
        begin
            share_reg <= div_q[31:0];
        end
        if (cmd.out_load)
        begin
            out_reg.reply_kind <= item_reg.action;
            out_reg.bad_index  <= bad && (item_reg.action != gwfr_pkg::ACT_RUN);
            if (item_reg.action == gwfr_pkg::ACT_READ && !bad)
            begin
                out_reg.water_out  <= rd_water_reg;
                out_reg.ground_out <= rd_ground_reg;
            end
            else
            begin
                out_reg.water_out  <= '0;
                out_reg.ground_out <= '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign sts.action    = item_reg.action;
    assign sts.bad       = bad;
    assign sts.run_empty = (n < EW'(3)) || (item_reg.pass_count == '0);
    assign sts.w_zero    = rd_water_reg == '0;
    assign sts.cnt_zero  = cnt_reg == '0;
    assign sts.k_last    = k_reg == 3'd7;
    assign sts.scan_last = (x_reg == n - EW'(2)) && (y_reg == n - EW'(2));
    assign sts.pass_last = pass_left_reg == 10'd1;
    assign sts.div_done  = div_done;
    assign sts.out_busy  = out_valid_reg && out_stall;

endmodule

@@ rtl/gwfr_ctrl.sv @@
// Controller state machine sequencing actions and relaxation passes.
`timescale 1ns / 1ps
module gwfr_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  gwfr_pkg::dp_status_t  sts,
    output gwfr_pkg::ctrl_cmd_t   cmd
);

    gwfr_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gwfr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = state_reg != gwfr_pkg::ST_IDLE;

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.addr_sel = gwfr_pkg::ADDR_CENTER;
        case (state_reg)
            gwfr_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = gwfr_pkg::ST_DISPATCH;
                end
            end
            gwfr_pkg::ST_DISPATCH:
            begin
                cmd.addr_sel = gwfr_pkg::ADDR_ITEM;
                case (sts.action)
                    gwfr_pkg::ACT_WRITE:
                    begin
                        cmd.wr_item = !sts.bad;
                        state_next  = gwfr_pkg::ST_POST;
                    end
                    gwfr_pkg::ACT_READ:
                    begin
                        cmd.rd     = !sts.bad;
                        state_next = gwfr_pkg::ST_POST;
                    end
                    gwfr_pkg::ACT_RUN:
                    begin
                        if (sts.run_empty)
                        begin
                            state_next = gwfr_pkg::ST_POST;
                        end
                        else
                        begin
                            cmd.scan_init = 1'b1;
                            cmd.pass_init = 1'b1;
                            state_next    = gwfr_pkg::ST_C_RD;
                        end
                    end
                    default:
                    begin
                        // drop: no reply for an unused action
                        state_next = gwfr_pkg::ST_IDLE;
                    end
                endcase
            end
            gwfr_pkg::ST_C_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = gwfr_pkg::ST_C_EVAL;
            end
            gwfr_pkg::ST_C_EVAL:
            begin
                cmd.cap_center = 1'b1;
                state_next     = sts.w_zero ? gwfr_pkg::ST_ADV : gwfr_pkg::ST_N_RD;
            end
            gwfr_pkg::ST_N_RD:
            begin
                cmd.addr_sel = gwfr_pkg::ADDR_NB;
                cmd.rd       = 1'b1;
                state_next   = gwfr_pkg::ST_N_EVAL;
            end
            gwfr_pkg::ST_N_EVAL:
            begin
                cmd.cap_nb = 1'b1;
                if (sts.k_last)
                begin
                    state_next = gwfr_pkg::ST_CHK;
                end
                else
                begin
                    cmd.k_inc  = 1'b1;
                    state_next = gwfr_pkg::ST_N_RD;
                end
            end
            gwfr_pkg::ST_CHK:
            begin
                if (sts.cnt_zero)
                begin
                    state_next = gwfr_pkg::ST_ADV;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = gwfr_pkg::ST_DIV_AVG;
                end
            end
            gwfr_pkg::ST_DIV_AVG:
            begin
                if (sts.div_done)
                begin
                    cmd.cap_avg = 1'b1;
                    state_next  = gwfr_pkg::ST_WR_C;
                end
            end
            gwfr_pkg::ST_WR_C:
            begin
                cmd.wr_center = 1'b1;
                cmd.div_start = 1'b1;
                cmd.div_share = 1'b1;
                state_next    = gwfr_pkg::ST_DIV_SHARE;
            end
            gwfr_pkg::ST_DIV_SHARE:
            begin
                if (sts.div_done)
                begin
                    cmd.cap_share = 1'b1;
                    cmd.k_clr     = 1'b1;
                    state_next    = gwfr_pkg::ST_UPD;
                end
            end
            gwfr_pkg::ST_UPD:
            begin
                cmd.addr_sel = gwfr_pkg::ADDR_NB;
                cmd.wr_nb    = 1'b1;
                cmd.k_inc    = 1'b1;
                if (sts.k_last)
                begin
                    state_next = gwfr_pkg::ST_ADV;
                end
            end
            gwfr_pkg::ST_ADV:
            begin
                if (!sts.scan_last)
                begin
                    cmd.scan_adv = 1'b1;
                    state_next   = gwfr_pkg::ST_C_RD;
                end
                else if (sts.pass_last)
                begin
                    state_next = gwfr_pkg::ST_POST;
                end
                else
                begin
                    cmd.pass_dec  = 1'b1;
                    cmd.scan_init = 1'b1;
                    state_next    = gwfr_pkg::ST_C_RD;
                end
            end
            gwfr_pkg::ST_POST:
            begin
                // hold until the result register is free
                if (!sts.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = gwfr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gwfr_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/grid_water_flow_relax_core.sv @@
// Grid water flow relaxation: controller, datapath and port wiring.
// Write and read actions pass through the dispatch and post states from acceptance to
// result. In each pass a run reads every interior cell; a cell with no water is skipped, a
// wet cell has its eight neighbours read, and a cell that sheds water also takes two
// divisions on the one-bit-per-cycle divider; the cell store is single-port.
// One action is in progress at a time; the result register frees the input side.
// Reset clears control state and sets grid_size 64, dry_threshold 66; the cell
// stores are not cleared and hold nothing defined until written.
`timescale 1ns / 1ps
module grid_water_flow_relax_core #(
    parameter int MAX_EDGE = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  gwfr_pkg::in_item_t              in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output gwfr_pkg::out_item_t             out_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic                            cfg_index,
    input  logic [gwfr_pkg::CFG_DATA_W-1:0] cfg_data
);

    gwfr_pkg::ctrl_cmd_t  cmd;
    gwfr_pkg::dp_status_t sts;

    assign cfg_ready = 1'b1;

    gwfr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    gwfr_dp #(
        .MAX_EDGE (MAX_EDGE)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
